### rtl/core/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg: shared types and constants of the feedback-queue scheduler
// Word formats, slot record layout, opcodes, status codes and unit controls.
// ----------------------------------------------------------------------------
package mlfq_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int LEVELS    = 4;
    localparam int CNT_W     = 16;
    localparam int PID_W     = 32;
    localparam int CHAN_W    = 32;
    localparam int TICK_W    = 32;
    localparam int SLICE_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [15:0]                    BOOST_RESET = 16'd100;
    localparam logic [LEVELS-1:0][SLICE_W-1:0] SLICE_RESET = {8'd8, 8'd4, 8'd2, 8'd1};

    typedef enum logic [2:0] {
        OP_ALLOC  = 3'd0,
        OP_PICK   = 3'd1,
        OP_YIELD  = 3'd2,
        OP_SLEEP  = 3'd3,
        OP_WAKEUP = 3'd4,
        OP_EXIT   = 3'd5,
        OP_FREE   = 3'd6,
        OP_QUERY  = 3'd7
    } t_opcode;

    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_SLEEPING = 3'd1;
    localparam logic [2:0] ST_RUNNABLE = 3'd2;
    localparam logic [2:0] ST_RUNNING  = 3'd3;
    localparam logic [2:0] ST_ZOMBIE   = 3'd4;

    localparam logic [1:0] RS_NORMAL = 2'd0;
    localparam logic [1:0] RS_IO     = 2'd1;
    localparam logic [1:0] RS_DEVICE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BOOST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE3 = 3'd4;

    typedef struct packed {
        t_opcode      opcode;
        logic [5:0]   slot;
        logic [31:0]  channel;
        logic [1:0]   wake_reason;
        logic [31:0]  tick;
    } t_in_word;

    typedef struct packed {
        logic         found;
        logic [5:0]   result_slot;
        logic [31:0]  process_id;
        logic [1:0]   level;
        logic [2:0]   slot_status;
        logic [15:0]  waited_ticks;
        logic [15:0]  run_ticks;
        logic [15:0]  preemptions;
        logic [15:0]  boosts;
        logic [15:0]  io_wakeups;
        logic [15:0]  device_wakeups;
        logic [1:0]   last_reason;
    } t_out_word;

    typedef struct packed {
        logic [2:0]         st;
        logic [1:0]         lvl;
        logic [SLICE_W-1:0] slice;
        logic [CHAN_W-1:0]  chan;
        logic [PID_W-1:0]   pid;
        logic [CNT_W-1:0]   wait_cnt;
        logic [CNT_W-1:0]   run_cnt;
        logic [CNT_W-1:0]   preempt_cnt;
        logic [CNT_W-1:0]   boost_cnt;
        logic [CNT_W-1:0]   io_cnt;
        logic [CNT_W-1:0]   dev_cnt;
        logic [1:0]         reason;
    } t_slot_rec;

    typedef enum logic [3:0] {
        M_AGE,
        M_WAKE,
        M_FIND_FREE,
        M_PICK,
        M_YIELD,
        M_SLEEP,
        M_EXIT,
        M_FREE,
        M_QUERY
    } t_alu_mode;

    typedef struct packed {
        t_alu_mode                    mode;
        logic                         boost;
        logic [1:0]                   lvl;
        logic [CHAN_W-1:0]            chan;
        logic [1:0]                   reason;
        logic [PID_W-1:0]             pid;
        logic [LEVELS-1:0][SLICE_W-1:0] slices;
    } t_alu_ctl;

endpackage

### rtl/core/mlfq_ram.sv
// ----------------------------------------------------------------------------
// mlfq_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle.
// ----------------------------------------------------------------------------
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/mlfq_slot_alu.sv
// ----------------------------------------------------------------------------
// mlfq_slot_alu: shared slot update unit
// Tests one slot record against the current operation and forms its new value.
// ----------------------------------------------------------------------------
module mlfq_slot_alu (
    input  mlfq_pkg::t_alu_ctl  i_ctl,
    input  mlfq_pkg::t_slot_rec i_rec,
    output mlfq_pkg::t_slot_rec o_rec,
    output logic                o_match
);
    import mlfq_pkg::*;

    logic [SLICE_W-1:0] slice_n;
    logic [1:0]         rsn;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    always_comb begin
        o_rec   = i_rec;
        o_match = 1'b0;
        slice_n = (i_rec.slice == '1) ? i_rec.slice : i_rec.slice + 1'b1;
        rsn     = (i_ctl.reason == RS_IO || i_ctl.reason == RS_DEVICE) ? i_ctl.reason
                                                                        : RS_NORMAL;
        case (i_ctl.mode)
            M_AGE: begin
                if (i_rec.st == ST_RUNNABLE) begin
                    o_rec.wait_cnt = sat_inc(i_rec.wait_cnt);
                end
                if (i_ctl.boost && i_rec.st != ST_UNUSED) begin
                    o_rec.lvl       = '0;
                    o_rec.slice     = '0;
                    o_rec.wait_cnt  = '0;
                    o_rec.boost_cnt = sat_inc(i_rec.boost_cnt);
                end
            end
            M_WAKE: begin
                o_match = (i_rec.st == ST_SLEEPING) && (i_rec.chan == i_ctl.chan);
                if (o_match) begin
                    o_rec.st     = ST_RUNNABLE;
                    o_rec.reason = rsn;
                    if (rsn != RS_NORMAL) begin
                        if (i_rec.lvl != '0) begin
                            o_rec.lvl = i_rec.lvl - 1'b1;
                        end
                        o_rec.slice = '0;
                        if (rsn == RS_IO) begin
                            o_rec.io_cnt = sat_inc(i_rec.io_cnt);
                        end else begin
                            o_rec.dev_cnt = sat_inc(i_rec.dev_cnt);
                        end
                    end
                end
            end
            M_FIND_FREE: begin
                o_match = (i_rec.st == ST_UNUSED);
                o_rec     = '0;
                o_rec.pid = i_ctl.pid;
                o_rec.st  = ST_RUNNABLE;
            end
            M_PICK: begin
                o_match = (i_rec.st == ST_RUNNABLE) && (i_rec.lvl == i_ctl.lvl);
                o_rec.wait_cnt = '0;
                o_rec.st       = ST_RUNNING;
            end
            M_YIELD: begin
                o_match = (i_rec.st == ST_RUNNING);
                if (o_match) begin
                    o_rec.run_cnt     = sat_inc(i_rec.run_cnt);
                    o_rec.preempt_cnt = sat_inc(i_rec.preempt_cnt);
                    o_rec.slice       = slice_n;
                    if (slice_n >= i_ctl.slices[i_rec.lvl]) begin
                        if (i_rec.lvl != 2'(LEVELS - 1)) begin
                            o_rec.lvl = i_rec.lvl + 1'b1;
                        end
                        o_rec.slice = '0;
                    end
                    o_rec.st = ST_RUNNABLE;
                end
            end
            M_SLEEP: begin
                o_match = (i_rec.st == ST_RUNNING);
                if (o_match) begin
                    o_rec.chan  = i_ctl.chan;
                    o_rec.slice = '0;
                    o_rec.st    = ST_SLEEPING;
                end
            end
            M_EXIT: begin
                o_match = (i_rec.st == ST_RUNNING);
                if (o_match) begin
                    o_rec.st = ST_ZOMBIE;
                end
            end
            M_FREE: begin
                o_match = (i_rec.st == ST_ZOMBIE);
                if (o_match) begin
                    o_rec = '0;
                end
            end
            M_QUERY: begin
                o_match = 1'b1;
            end
            default: begin
                o_match = 1'b0;
            end
        endcase
    end
endmodule

### rtl/core/mlfq_process_scheduler_unit.sv
// ----------------------------------------------------------------------------
// mlfq_process_scheduler_unit: four-level feedback-queue process scheduler
// Slot table in RAM, walked by a small sequencer through one shared slot unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one command word: opcode,
//   slot, channel, wake reason and tick. Output channel (o_out_valid /
//   i_out_ready) returns exactly one result word per command.
//   Configuration: i_cfg_we writes boost interval (index 0) or the level
//   slices (indexes 1 to 4); write only while idle.
//   One command at a time; o_in_ready stays low until its result is loaded
//   into the output register. A wakeup sweeps every slot; an alloc scans
//   for a free slot; a pick sweeps every slot for aging and boost, then
//   scans up to four levels. The single read port of the slot RAM sets the
//   pace: one slot is visited per cycle. Reset clears all slots at once
//   through per-slot valid bits (an invalid slot reads as unused and zero),
//   cursors, last boost tick and sets the next id to 1. If the receiver
//   stalls, the result word holds in the output register; the next command
//   is accepted meanwhile and waits at its end until the register frees.
// ----------------------------------------------------------------------------
module mlfq_process_scheduler_unit #(
    parameter int SLOTS = mlfq_pkg::SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  mlfq_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output mlfq_pkg::t_out_word                o_out_word,
    input  logic                               i_cfg_we,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mlfq_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import mlfq_pkg::*;

    localparam int SW = $clog2(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SINGLE,
        S_SWEEP,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                         r_state;
    t_in_word                       r_word;
    logic [SW-1:0]                  r_addr;
    logic [SW:0]                    r_cnt;
    logic                           r_pend;
    logic [SW-1:0]                  r_paddr;
    logic [1:0]                     r_lv;
    logic                           r_boost;
    logic                           r_any;
    logic                           r_rvld;
    t_out_word                      r_rep;
    t_out_word                      r_out;
    logic                           r_out_vld;
    logic [SLOTS-1:0]               r_valid;
    logic [LEVELS-1:0][SW-1:0]      r_cursor;
    logic [TICK_W-1:0]              r_last_boost;
    logic [PID_W-1:0]               r_next_id;
    logic [15:0]                    r_boost_ivl;
    logic [LEVELS-1:0][SLICE_W-1:0] r_slices;

    logic       accept;
    logic       in_range;
    logic       issue;
    logic       rd_en;
    logic [SW-1:0] rd_addr;
    logic       wr_en;
    logic [$bits(t_slot_rec)-1:0] ram_rdata;
    t_slot_rec  rd_rec;
    t_slot_rec  alu_rec;
    logic       alu_match;
    t_alu_ctl   alu_ctl;

    function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] a);
        return (a == SW'(SLOTS - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic t_out_word mk_out(input logic found, input logic [SW-1:0] s,
                                         input t_slot_rec rec);
        t_out_word w;
        w.found          = found;
        w.result_slot    = 6'(s);
        w.process_id     = rec.pid;
        w.level          = rec.lvl;
        w.slot_status    = rec.st;
        w.waited_ticks   = 16'(rec.wait_cnt);
        w.run_ticks      = 16'(rec.run_cnt);
        w.preemptions    = 16'(rec.preempt_cnt);
        w.boosts         = 16'(rec.boost_cnt);
        w.io_wakeups     = 16'(rec.io_cnt);
        w.device_wakeups = 16'(rec.dev_cnt);
        w.last_reason    = rec.reason;
        return w;
    endfunction

    function automatic t_out_word none_out(input logic [5:0] s);
        t_out_word w;
        w             = '0;
        w.result_slot = s;
        return w;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign in_range    = (32'(i_in_word.slot) < SLOTS);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // one read a cycle while the walk has slots left to visit
    assign issue = (r_state == S_SWEEP || r_state == S_SCAN) && (r_cnt < (SW+1)'(SLOTS));

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_addr;
        if (accept && in_range) begin
            rd_en   = 1'b1;
            rd_addr = SW'(i_in_word.slot);
        end else if (issue) begin
            rd_en = 1'b1;
        end
    end

    // invalid slots read as the cleared record
    assign rd_rec = r_rvld ? t_slot_rec'(ram_rdata) : '0;

    always_comb begin
        alu_ctl        = '0;
        alu_ctl.boost  = r_boost;
        alu_ctl.lvl    = r_lv;
        alu_ctl.chan   = r_word.channel;
        alu_ctl.reason = r_word.wake_reason;
        alu_ctl.pid    = r_next_id;
        alu_ctl.slices = r_slices;
        case (r_word.opcode)
            OP_ALLOC:  alu_ctl.mode = M_FIND_FREE;
            OP_PICK:   alu_ctl.mode = (r_state == S_SCAN) ? M_PICK : M_AGE;
            OP_YIELD:  alu_ctl.mode = M_YIELD;
            OP_SLEEP:  alu_ctl.mode = M_SLEEP;
            OP_WAKEUP: alu_ctl.mode = M_WAKE;
            OP_EXIT:   alu_ctl.mode = M_EXIT;
            OP_FREE:   alu_ctl.mode = M_FREE;
            OP_QUERY:  alu_ctl.mode = M_QUERY;
            default:   alu_ctl.mode = M_QUERY;
        endcase
    end

    always_comb begin
        case (r_state)
            S_SINGLE: wr_en = alu_match;
            S_SWEEP:  wr_en = r_pend;
            S_SCAN:   wr_en = r_pend && alu_match;
            default:  wr_en = 1'b0;
        endcase
    end

    mlfq_slot_alu u_alu (
        .i_ctl   (alu_ctl),
        .i_rec   (rd_rec),
        .o_rec   (alu_rec),
        .o_match (alu_match)
    );

    mlfq_ram #(
        .WIDTH ($bits(t_slot_rec)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_paddr),
        .i_wdata (alu_rec),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend       <= 1'b0;
            r_out_vld    <= 1'b0;
            r_valid      <= '0;
            r_cursor     <= '0;
            r_last_boost <= '0;
            r_next_id    <= PID_W'(1);
            r_boost_ivl  <= BOOST_RESET;
            r_slices     <= SLICE_RESET;
            r_rvld       <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BOOST:  r_boost_ivl <= i_cfg_wdata;
                    CFG_SLICE0: r_slices[0] <= SLICE_W'(i_cfg_wdata);
                    CFG_SLICE1: r_slices[1] <= SLICE_W'(i_cfg_wdata);
                    CFG_SLICE2: r_slices[2] <= SLICE_W'(i_cfg_wdata);
                    CFG_SLICE3: r_slices[3] <= SLICE_W'(i_cfg_wdata);
                    default: ;
                endcase
            end

            if (rd_en) begin
                r_rvld <= r_valid[rd_addr];
            end
            if (wr_en) begin
                r_valid[r_paddr] <= 1'b1;
            end
            // load a new result word, or drop the one just taken
            if (r_state == S_DONE && (!r_out_vld || i_out_ready)) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_word  <= i_in_word;
                        r_addr  <= '0;
                        r_cnt   <= '0;
                        r_pend  <= 1'b0;
                        r_lv    <= '0;
                        r_any   <= 1'b0;
                        r_boost <= (i_in_word.tick - r_last_boost) >= TICK_W'(r_boost_ivl);
                        r_paddr <= SW'(i_in_word.slot);
                        case (i_in_word.opcode)
                            OP_ALLOC:  r_state <= S_SCAN;
                            OP_PICK:   r_state <= S_SWEEP;
                            OP_WAKEUP: r_state <= S_SWEEP;
                            default: begin
                                if (in_range) begin
                                    r_state <= S_SINGLE;
                                end else begin
                                    r_rep   <= none_out(i_in_word.slot);
                                    r_state <= S_DONE;
                                end
                            end
                        endcase
                    end
                end

                S_SINGLE: begin
                    r_rep   <= mk_out(alu_match, r_paddr, alu_rec);
                    r_state <= S_DONE;
                end

                // visit every slot: aging and boost for pick, matching for wakeup
                S_SWEEP: begin
                    if (issue) begin
                        r_addr <= wrap_inc(r_addr);
                        r_cnt  <= r_cnt + 1'b1;
                    end
                    r_pend  <= issue;
                    r_paddr <= r_addr;
                    if (r_pend && alu_match && !r_any) begin
                        r_any <= 1'b1;
                        r_rep <= mk_out(1'b1, r_paddr, alu_rec);
                    end
                    if (!issue && !r_pend) begin
                        if (r_word.opcode == OP_PICK) begin
                            if (r_boost) begin
                                r_last_boost <= r_word.tick;
                            end
                            r_lv    <= '0;
                            r_addr  <= r_cursor[0];
                            r_cnt   <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            if (!r_any) begin
                                r_rep <= none_out('0);
                            end
                            r_state <= S_DONE;
                        end
                    end
                end

                // search from a start slot, stop at the first match
                S_SCAN: begin
                    if (r_pend && alu_match) begin
                        r_rep  <= mk_out(1'b1, r_paddr, alu_rec);
                        r_pend <= 1'b0;
                        if (r_word.opcode == OP_ALLOC) begin
                            r_next_id <= r_next_id + 1'b1;
                        end else begin
                            r_cursor[r_lv] <= wrap_inc(r_paddr);
                        end
                        r_state <= S_DONE;
                    end else begin
                        if (issue) begin
                            r_addr <= wrap_inc(r_addr);
                            r_cnt  <= r_cnt + 1'b1;
                        end
                        r_pend  <= issue;
                        r_paddr <= r_addr;
                        if (!issue && !r_pend) begin
                            if (r_word.opcode == OP_ALLOC || r_lv == 2'(LEVELS - 1)) begin
                                r_rep   <= none_out('0);
                                r_state <= S_DONE;
                            end else begin
                                r_lv   <= r_lv + 1'b1;
                                r_addr <= r_cursor[r_lv + 1'b1];
                                r_cnt  <= '0;
                            end
                        end
                    end
                end

                // hand over to the output register once it is free
                S_DONE: begin
                    if (!r_out_vld || i_out_ready) begin
                        r_out     <= r_rep;
                        r_state   <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/core/mlfq_checker.sv
// ----------------------------------------------------------------------------
// mlfq_checker: port-level checks of the scheduler
// Watches both channels of the top level over time.
// ----------------------------------------------------------------------------
module mlfq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input mlfq_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input mlfq_pkg::t_out_word o_out_word
);
    import mlfq_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word dropped or changed while stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_word))
        else $error("command word dropped or changed while waiting");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken while a command is in progress");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after accept");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.slot_status <= ST_ZOMBIE)
        else $error("illegal slot status reported");
endmodule

bind mlfq_process_scheduler_unit mlfq_checker u_mlfq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

### tb/tb_mlfq_process_scheduler_unit.sv
// ----------------------------------------------------------------------------
// tb_mlfq_process_scheduler_unit: self-checking bench of the feedback-queue scheduler
// A directed table walks every opcode and the empty, wrong-state and wrap
// cases. Random command traffic then runs under several slice and boost
// settings. Every accepted command is run through a local copy of the
// scheduler state, and each result word is compared field by field.
// ----------------------------------------------------------------------------
module tb_mlfq_process_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mlfq_pkg::*;

    localparam int NSLOT      = 64;
    localparam int LIMIT_CYC  = 1_500_000;
    localparam int HOLD_CYC   = 600;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #10 i_clk = ~i_clk;

    // DUT ports, all inputs known from time zero
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_word   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;

    mlfq_process_scheduler_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Scheduler shadow: slot table, cursors and settings as the block keeps them
    // ------------------------------------------------------------------------
    logic [2:0]         sh_state   [NSLOT];
    logic [1:0]         sh_level   [NSLOT];
    logic [7:0]         sh_slice   [NSLOT];
    logic [31:0]        sh_chan    [NSLOT];
    logic [31:0]        sh_pid     [NSLOT];
    logic [15:0]        sh_wait    [NSLOT];
    logic [15:0]        sh_run     [NSLOT];
    logic [15:0]        sh_preempt [NSLOT];
    logic [15:0]        sh_boost   [NSLOT];
    logic [15:0]        sh_io      [NSLOT];
    logic [15:0]        sh_dev     [NSLOT];
    logic [1:0]         sh_reason  [NSLOT];
    logic [5:0]         sh_cursor  [LEVELS];
    logic [31:0]        sh_last_boost;
    logic [31:0]        sh_next_pid;
    logic [15:0]        boost_period;
    logic [7:0]         slice_len  [LEVELS];

    t_out_word          pending_results[$];
    int                 fail_count = 0;
    bit                 hold_off_req = 1'b0;

    function automatic logic [15:0] sat16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic void wipe_slot(input int s);
        sh_state[s]   = ST_UNUSED;
        sh_level[s]   = '0;
        sh_slice[s]   = '0;
        sh_chan[s]    = '0;
        sh_pid[s]     = '0;
        sh_wait[s]    = '0;
        sh_run[s]     = '0;
        sh_preempt[s] = '0;
        sh_boost[s]   = '0;
        sh_io[s]      = '0;
        sh_dev[s]     = '0;
        sh_reason[s]  = '0;
    endfunction

    function automatic t_out_word slot_report(input logic hit, input int s);
        t_out_word r;
        r.found          = hit;
        r.result_slot    = s[5:0];
        r.process_id     = sh_pid[s];
        r.level          = sh_level[s];
        r.slot_status    = sh_state[s];
        r.waited_ticks   = sh_wait[s];
        r.run_ticks      = sh_run[s];
        r.preemptions    = sh_preempt[s];
        r.boosts         = sh_boost[s];
        r.io_wakeups     = sh_io[s];
        r.device_wakeups = sh_dev[s];
        r.last_reason    = sh_reason[s];
        return r;
    endfunction

    function automatic void shadow_reset();
        for (int s = 0; s < NSLOT; s++) wipe_slot(s);
        for (int l = 0; l < LEVELS; l++) begin
            sh_cursor[l] = '0;
            slice_len[l] = SLICE_RESET[l];
        end
        sh_last_boost = '0;
        sh_next_pid   = 32'd1;
        boost_period  = BOOST_RESET;
    endfunction

    // Advance the shadow by one command and return the word the block must give
    function automatic t_out_word schedule_step(input t_in_word w);
        t_out_word r;
        int        s;
        int        idx;
        int        lv;
        logic [1:0] rs;
        bit        woke;
        r = '0;
        s = w.slot;
        case (w.opcode)
            OP_ALLOC: begin
                for (s = 0; s < NSLOT; s++) begin
                    if (sh_state[s] == ST_UNUSED) begin
                        wipe_slot(s);
                        sh_pid[s]   = sh_next_pid;
                        sh_next_pid = sh_next_pid + 32'd1;
                        sh_state[s] = ST_RUNNABLE;
                        return slot_report(1'b1, s);
                    end
                end
            end
            OP_PICK: begin
                // age, then maybe boost, then scan levels from the top
                for (s = 0; s < NSLOT; s++)
                    if (sh_state[s] == ST_RUNNABLE) sh_wait[s] = sat16(sh_wait[s]);
                if ((w.tick - sh_last_boost) >= {16'd0, boost_period}) begin
                    sh_last_boost = w.tick;
                    for (s = 0; s < NSLOT; s++) begin
                        if (sh_state[s] != ST_UNUSED) begin
                            sh_level[s] = '0;
                            sh_slice[s] = '0;
                            sh_wait[s]  = '0;
                            sh_boost[s] = sat16(sh_boost[s]);
                        end
                    end
                end
                for (lv = 0; lv < LEVELS; lv++) begin
                    for (int i = 0; i < NSLOT; i++) begin
                        idx = (sh_cursor[lv] + i) % NSLOT;
                        if (sh_state[idx] == ST_RUNNABLE && sh_level[idx] == lv) begin
                            sh_cursor[lv] = 6'((idx + 1) % NSLOT);
                            sh_wait[idx]  = '0;
                            sh_state[idx] = ST_RUNNING;
                            return slot_report(1'b1, idx);
                        end
                    end
                end
            end
            OP_WAKEUP: begin
                rs   = (w.wake_reason == 2'd3) ? RS_NORMAL : w.wake_reason;
                woke = 1'b0;
                idx  = 0;
                for (s = 0; s < NSLOT; s++) begin
                    if (sh_state[s] == ST_SLEEPING && sh_chan[s] == w.channel) begin
                        sh_state[s]  = ST_RUNNABLE;
                        sh_reason[s] = rs;
                        if (rs != RS_NORMAL) begin
                            if (sh_level[s] != 0) sh_level[s] = sh_level[s] - 2'd1;
                            sh_slice[s] = '0;
                            if (rs == RS_IO) sh_io[s] = sat16(sh_io[s]);
                            else             sh_dev[s] = sat16(sh_dev[s]);
                        end
                        if (!woke) idx = s;
                        woke = 1'b1;
                    end
                end
                if (woke) return slot_report(1'b1, idx);
            end
            OP_YIELD: begin
                if (sh_state[s] != ST_RUNNING) return slot_report(1'b0, s);
                lv = sh_level[s];
                sh_run[s]     = sat16(sh_run[s]);
                sh_preempt[s] = sat16(sh_preempt[s]);
                if (sh_slice[s] != 8'hFF) sh_slice[s] = sh_slice[s] + 8'd1;
                if (sh_slice[s] >= slice_len[lv]) begin
                    if (lv < LEVELS - 1) sh_level[s] = 2'(lv + 1);
                    sh_slice[s] = '0;
                end
                sh_state[s] = ST_RUNNABLE;
                return slot_report(1'b1, s);
            end
            OP_SLEEP: begin
                if (sh_state[s] != ST_RUNNING) return slot_report(1'b0, s);
                sh_chan[s]  = w.channel;
                sh_slice[s] = '0;
                sh_state[s] = ST_SLEEPING;
                return slot_report(1'b1, s);
            end
            OP_EXIT: begin
                if (sh_state[s] != ST_RUNNING) return slot_report(1'b0, s);
                sh_state[s] = ST_ZOMBIE;
                return slot_report(1'b1, s);
            end
            OP_FREE: begin
                if (sh_state[s] != ST_ZOMBIE) return slot_report(1'b0, s);
                wipe_slot(s);
                return slot_report(1'b1, s);
            end
            default: return slot_report(1'b1, s);
        endcase
        // nothing found: all-zero word
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Cycle limit
    // ------------------------------------------------------------------------
    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYC) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int busy_mode;
        int run_len;
        busy_mode = 0;
        run_len   = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                // hold off long enough for the command side to back up
                i_out_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYC; c++) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            if (run_len == 0) begin
                busy_mode = $urandom_range(0, 2);
                run_len   = $urandom_range(20, 80);
            end
            run_len--;
            if (busy_mode == 0) begin
                i_out_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 12) begin
                // stall: mostly short, sometimes long
                i_out_ready <= 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3))
                    @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result word against the oldest expectation
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no command outstanding");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (want.found != o_out_word.found) begin
                    $error("found: exp %0d act %0d", want.found, o_out_word.found);
                    fail_count++;
                end
                if (want.result_slot != o_out_word.result_slot) begin
                    $error("result_slot: exp %0d act %0d", want.result_slot,
                           o_out_word.result_slot);
                    fail_count++;
                end
                if (want.process_id != o_out_word.process_id) begin
                    $error("process_id: exp %0d act %0d", want.process_id,
                           o_out_word.process_id);
                    fail_count++;
                end
                if (want.level != o_out_word.level) begin
                    $error("level: exp %0d act %0d", want.level, o_out_word.level);
                    fail_count++;
                end
                if (want.slot_status != o_out_word.slot_status) begin
                    $error("slot_status: exp %0d act %0d", want.slot_status,
                           o_out_word.slot_status);
                    fail_count++;
                end
                if (want.waited_ticks != o_out_word.waited_ticks) begin
                    $error("waited_ticks: exp %0d act %0d", want.waited_ticks,
                           o_out_word.waited_ticks);
                    fail_count++;
                end
                if (want.run_ticks != o_out_word.run_ticks) begin
                    $error("run_ticks: exp %0d act %0d", want.run_ticks,
                           o_out_word.run_ticks);
                    fail_count++;
                end
                if (want.preemptions != o_out_word.preemptions) begin
                    $error("preemptions: exp %0d act %0d", want.preemptions,
                           o_out_word.preemptions);
                    fail_count++;
                end
                if (want.boosts != o_out_word.boosts) begin
                    $error("boosts: exp %0d act %0d", want.boosts, o_out_word.boosts);
                    fail_count++;
                end
                if (want.io_wakeups != o_out_word.io_wakeups) begin
                    $error("io_wakeups: exp %0d act %0d", want.io_wakeups,
                           o_out_word.io_wakeups);
                    fail_count++;
                end
                if (want.device_wakeups != o_out_word.device_wakeups) begin
                    $error("device_wakeups: exp %0d act %0d", want.device_wakeups,
                           o_out_word.device_wakeups);
                    fail_count++;
                end
                if (want.last_reason != o_out_word.last_reason) begin
                    $error("last_reason: exp %0d act %0d", want.last_reason,
                           o_out_word.last_reason);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    bit          gapless = 1'b0;
    logic [31:0] tick_now = '0;
    logic [31:0] chan_pool[4];

    // Offer one command word, hold it until taken, then record its result.
    // A typed expectation replaces the shadow's word, the shadow still advances.
    task automatic send_command(input t_in_word w, input bit typed, input t_out_word typed_exp);
        t_out_word want;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        want = schedule_step(w);
        pending_results.push_back(typed ? typed_exp : want);
        if (!gapless && $urandom_range(0, 99) < 45) begin
            i_in_valid <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(1, 4))
                @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_BOOST) boost_period = val;
        else                  slice_len[idx - CFG_SLICE0] = val[7:0];
    endtask

    task automatic set_config(input logic [15:0] bp, input logic [7:0] s0,
                              input logic [7:0] s1, input logic [7:0] s2,
                              input logic [7:0] s3);
        write_reg(CFG_BOOST, bp);
        write_reg(CFG_SLICE0, {8'd0, s0});
        write_reg(CFG_SLICE1, {8'd0, s1});
        write_reg(CFG_SLICE2, {8'd0, s2});
        write_reg(CFG_SLICE3, {8'd0, s3});
    endtask

    // Random slot in the given status, or any slot when none is (and one time in twenty)
    function automatic logic [5:0] slot_with(input logic [2:0] st);
        int hits[$];
        for (int s = 0; s < NSLOT; s++) if (sh_state[s] == st) hits.push_back(s);
        if (hits.size() == 0 || $urandom_range(0, 19) == 0) return 6'($urandom_range(0, 63));
        return 6'(hits[$urandom_range(0, hits.size() - 1)]);
    endfunction

    function automatic t_in_word random_command();
        t_in_word w;
        int       r;
        w.slot        = 6'($urandom_range(0, 63));
        w.channel     = $urandom();
        w.wake_reason = 2'($urandom_range(0, 3));
        // move time forward; jump anywhere now and then to hit wrap
        if ($urandom_range(0, 39) == 0) tick_now = $urandom();
        else                            tick_now = tick_now + $urandom_range(0, 60);
        w.tick = tick_now;
        r = $urandom_range(0, 99);
        if      (r < 14) w.opcode = OP_ALLOC;
        else if (r < 40) w.opcode = OP_PICK;
        else if (r < 60) w.opcode = OP_YIELD;
        else if (r < 70) w.opcode = OP_SLEEP;
        else if (r < 81) w.opcode = OP_WAKEUP;
        else if (r < 87) w.opcode = OP_EXIT;
        else if (r < 92) w.opcode = OP_FREE;
        else             w.opcode = OP_QUERY;
        case (w.opcode)
            OP_YIELD, OP_SLEEP, OP_EXIT: w.slot = slot_with(ST_RUNNING);
            OP_FREE:                     w.slot = slot_with(ST_ZOMBIE);
            default: ;
        endcase
        // keep wait channels to a small pool so wakeups find sleepers
        if ((w.opcode == OP_SLEEP || w.opcode == OP_WAKEUP) && $urandom_range(0, 9) != 0)
            w.channel = chan_pool[$urandom_range(0, 3)];
        return w;
    endfunction

    task automatic random_phase(input int n_items);
        for (int c = 0; c < 4; c++) chan_pool[c] = $urandom();
        for (int k = 0; k < n_items; k++) begin
            if (k % 40 == 0) gapless = ($urandom_range(0, 3) == 0);
            send_command(random_command(), 1'b0, '0);
        end
        gapless = 1'b0;
    endtask

    // Directed table
    typedef struct {
        t_in_word  cmd;
        bit        typed;
        t_out_word want;
    } t_dir_row;

    function automatic t_in_word mk_cmd(input t_opcode op, input logic [5:0] s,
                                        input logic [31:0] ch, input logic [1:0] rs,
                                        input logic [31:0] tk);
        t_in_word w;
        w.opcode = op; w.slot = s; w.channel = ch; w.wake_reason = rs; w.tick = tk;
        return w;
    endfunction

    function automatic t_out_word mk_bare(input logic hit, input logic [5:0] s,
                                          input logic [31:0] p, input logic [2:0] st);
        t_out_word r;
        r = '0;
        r.found = hit; r.result_slot = s; r.process_id = p; r.slot_status = st;
        return r;
    endfunction

    initial begin : stimulus
        t_dir_row rows[$];
        shadow_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // query of an empty table, empty pick, ops on an unused slot, empty wakeup
        rows.push_back('{mk_cmd(OP_QUERY, 6'd63, '0, 2'd0, '0), 1,
                         mk_bare(1'b1, 6'd63, '0, ST_UNUSED)});
        rows.push_back('{mk_cmd(OP_PICK, 6'd0, '0, 2'd0, '0), 1,
                         mk_bare(1'b0, 6'd0, '0, ST_UNUSED)});
        rows.push_back('{mk_cmd(OP_YIELD, 6'd0, '0, 2'd0, '0), 1,
                         mk_bare(1'b0, 6'd0, '0, ST_UNUSED)});
        rows.push_back('{mk_cmd(OP_FREE, 6'd0, '0, 2'd0, '0), 1,
                         mk_bare(1'b0, 6'd0, '0, ST_UNUSED)});
        rows.push_back('{mk_cmd(OP_WAKEUP, 6'd0, '0, RS_IO, '0), 1,
                         mk_bare(1'b0, 6'd0, '0, ST_UNUSED)});
        rows.push_back('{mk_cmd(OP_ALLOC, 6'd42, '0, 2'd0, '0), 1,
                         mk_bare(1'b1, 6'd0, 32'd1, ST_RUNNABLE)});
        rows.push_back('{mk_cmd(OP_ALLOC, 6'd0, '0, 2'd0, '0), 1,
                         mk_bare(1'b1, 6'd1, 32'd2, ST_RUNNABLE)});
        rows.push_back('{mk_cmd(OP_PICK, 6'd0, '0, 2'd0, 32'd0), 1,
                         mk_bare(1'b1, 6'd0, 32'd1, ST_RUNNING)});
        // the rest follows from the shadow
        rows.push_back('{mk_cmd(OP_YIELD, 6'd0, '0, 2'd0, '0), 0, '0});
        rows.push_back('{mk_cmd(OP_PICK, 6'd0, '0, 2'd0, 32'd100), 0, '0});
        rows.push_back('{mk_cmd(OP_SLEEP, 6'd1, 32'hFFFF_FFFF, 2'd0, '0), 0, '0});
        rows.push_back('{mk_cmd(OP_WAKEUP, 6'd0, 32'hFFFF_FFFF, RS_IO, '0), 0, '0});
        rows.push_back('{mk_cmd(OP_PICK, 6'd0, '0, 2'd0, 32'hFFFF_FFFF), 0, '0});
        rows.push_back('{mk_cmd(OP_SLEEP, 6'd0, 32'h1234_5678, 2'd0, '0), 0, '0});
        rows.push_back('{mk_cmd(OP_SLEEP, 6'd1, 32'h1234_5678, 2'd0, '0), 0, '0});
        rows.push_back('{mk_cmd(OP_WAKEUP, 6'd0, 32'h1234_5678, RS_DEVICE, '0), 0, '0});
        rows.push_back('{mk_cmd(OP_PICK, 6'd0, '0, 2'd0, 32'd5), 0, '0});
        rows.push_back('{mk_cmd(OP_SLEEP, 6'd0, 32'd0, 2'd0, '0), 0, '0});
        rows.push_back('{mk_cmd(OP_WAKEUP, 6'd0, 32'd0, 2'd3, '0), 0, '0});
        rows.push_back('{mk_cmd(OP_PICK, 6'd0, '0, 2'd0, 32'd6), 0, '0});
        rows.push_back('{mk_cmd(OP_EXIT, 6'd0, '0, 2'd0, '0), 0, '0});
        rows.push_back('{mk_cmd(OP_EXIT, 6'd1, '0, 2'd0, '0), 0, '0});
        rows.push_back('{mk_cmd(OP_FREE, 6'd0, '0, 2'd0, '0), 0, '0});
        rows.push_back('{mk_cmd(OP_FREE, 6'd1, '0, 2'd0, '0), 0, '0});
        rows.push_back('{mk_cmd(OP_QUERY, 6'd1, '0, 2'd0, '0), 0, '0});
        foreach (rows[i]) send_command(rows[i].cmd, rows[i].typed, rows[i].want);

        // reset settings
        random_phase(110);
        drain_results();

        // tightest settings; fill the whole table, then hold off the result side
        set_config(16'd1, 8'd1, 8'd1, 8'd1, 8'd1);
        for (int k = 0; k < 66; k++)
            send_command(mk_cmd(OP_ALLOC, 6'($urandom_range(0, 63)), $urandom(),
                                2'($urandom_range(0, 3)), tick_now), 1'b0, '0);
        hold_off_req = 1'b1;
        random_phase(110);
        drain_results();

        // widest settings
        set_config(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        random_phase(110);
        drain_results();

        // random mid-range settings
        set_config(16'($urandom_range(1, 200)), 8'($urandom_range(1, 4)),
                   8'($urandom_range(1, 6)), 8'($urandom_range(1, 8)),
                   8'($urandom_range(1, 12)));
        random_phase(110);
        drain_results();
        repeat (20) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
